// ===== rtl/segment_sphere_intersect_test_assert.svh =====
// assertion macros for the segment/sphere test rtl
// expects signals named clock and reset in the including module
`ifndef SEGMENT_SPHERE_INTERSECT_TEST_ASSERT_SVH
`define SEGMENT_SPHERE_INTERSECT_TEST_ASSERT_SVH

// same-cycle implication, quiet during reset
`define SSIT_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ssit assertion failed");

// next-cycle implication, quiet during reset
`define SSIT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ssit assertion failed");

// condition that must hold in the cycle after reset
`define SSIT_ASSERT_AFTER_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("ssit assertion failed");

`endif

// ===== rtl/ssit_pkg.sv =====
// shared widths and pipeline record types for the segment/sphere test
// no dependencies
package ssit_pkg;

   localparam int COORD_W         = 32;
   localparam int RAD_W           = 31;
   localparam int DIFF_W          = COORD_W + 1;
   localparam int DSQ_W           = 64;
   localparam int DOT_W           = 66;
   localparam int T_FRAC_BITS_DEF = 16;

   typedef struct packed {
      logic [2:0][DIFF_W-1:0]  oc;
      logic [2:0][COORD_W-1:0] dmag;
      logic [2:0]              dneg;
      logic [RAD_W-1:0]        r;
   } geom_type;

   typedef struct packed {
      logic             vld;
      logic             pos;
      logic             sat;
      logic [DSQ_W-1:0] dsq;
      logic [DSQ_W-1:0] rem;
      geom_type         g;
   } div_type;

endpackage

// ===== rtl/ssit_front.sv =====
// front stages: differences, products, dot product and squared length
// depends on ssit_pkg
module ssit_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   adv,
   input  logic                                   in_vld,
   input  logic [2:0][ssit_pkg::COORD_W-1:0]      org,
   input  logic [2:0][ssit_pkg::COORD_W-1:0]      dir,
   input  logic [2:0][ssit_pkg::COORD_W-1:0]      cen,
   input  logic [ssit_pkg::RAD_W-1:0]             rad,
   output ssit_pkg::div_type                      div_out
);
   import ssit_pkg::*;

   logic                     s1_vld_ff;
   logic [2:0][DIFF_W-1:0]   s1_vmag_ff, s1_vmag_in;
   logic [2:0]               s1_sgn_ff, s1_sgn_in;
   geom_type                 s1_g_ff, s1_g_in;

   logic                     s2_vld_ff;
   logic [2:0][DSQ_W-1:0]    s2_pv_ff, s2_pv_in;
   logic [2:0][DSQ_W-1:0]    s2_dq_ff, s2_dq_in;
   logic [2:0]               s2_sgn_ff;
   geom_type                 s2_g_ff;

   logic                     s3_vld_ff;
   logic signed [DOT_W-1:0]  s3_dot_ff, s3_dot_in;
   logic [DSQ_W-1:0]         s3_dsq_ff, s3_dsq_in;
   geom_type                 s3_g_ff;

   div_type                  s4_ff, s4_in;

   always_comb begin
      logic [DIFF_W-1:0] v;
      logic [DIFF_W-1:0] dm;
      s1_g_in.r = rad;
      for (int i = 0; i < 3; i++) begin
         v  = {cen[i][COORD_W-1], cen[i]} - {org[i][COORD_W-1], org[i]};
         dm = {dir[i][COORD_W-1], dir[i]};
         s1_vmag_in[i]    = v[DIFF_W-1] ? -v : v;
         s1_g_in.oc[i]    = -v;
         s1_g_in.dmag[i]  = dm[DIFF_W-1] ? COORD_W'(-dm) : COORD_W'(dm);
         s1_g_in.dneg[i]  = dir[i][COORD_W-1];
         s1_sgn_in[i]     = v[DIFF_W-1] ^ dir[i][COORD_W-1];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_pv_in[i] = DSQ_W'(s1_vmag_ff[i]) * DSQ_W'(s1_g_ff.dmag[i]);
         s2_dq_in[i] = DSQ_W'(s1_g_ff.dmag[i]) * DSQ_W'(s1_g_ff.dmag[i]);
      end
   end

   always_comb begin
      logic signed [DOT_W-1:0] term;
      s3_dot_in = '0;
      for (int i = 0; i < 3; i++) begin
         term      = $signed({2'b00, s2_pv_ff[i]});
         s3_dot_in = s2_sgn_ff[i] ? s3_dot_in - term : s3_dot_in + term;
      end
      s3_dsq_in = s2_dq_ff[0] + s2_dq_ff[1] + s2_dq_ff[2];
   end

   always_comb begin
      s4_in.vld = s3_vld_ff;
      s4_in.pos = !s3_dot_ff[DOT_W-1] && (s3_dot_ff != '0);
      s4_in.sat = s3_dot_ff[DOT_W-2:0] >= {1'b0, s3_dsq_ff};
      s4_in.dsq = s3_dsq_ff;
      s4_in.rem = s3_dot_ff[DSQ_W-1:0];
      s4_in.g   = s3_g_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_ff.vld <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= in_vld;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_ff     <= s4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_vmag_ff <= s1_vmag_in;
         s1_sgn_ff  <= s1_sgn_in;
         s1_g_ff    <= s1_g_in;
         s2_pv_ff   <= s2_pv_in;
         s2_dq_ff   <= s2_dq_in;
         s2_sgn_ff  <= s1_sgn_ff;
         s2_g_ff    <= s1_g_ff;
         s3_dot_ff  <= s3_dot_in;
         s3_dsq_ff  <= s3_dsq_in;
         s3_g_ff    <= s2_g_ff;
      end
   end

   assign div_out = s4_ff;

endmodule

// ===== rtl/ssit_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with clamp to [0,1]
// depends on ssit_pkg
module ssit_div #(
   parameter int T_FRAC_BITS = ssit_pkg::T_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  ssit_pkg::div_type    div_in,
   output logic                 out_vld,
   output logic [T_FRAC_BITS:0] tq,
   output ssit_pkg::geom_type   geom
);
   import ssit_pkg::*;

   div_type                st_ff [T_FRAC_BITS];
   logic [T_FRAC_BITS-1:0] q_ff  [T_FRAC_BITS];

   for (genvar k = 0; k < T_FRAC_BITS; k++) begin : g_bit
      div_type                src;
      logic [T_FRAC_BITS-1:0] qsrc;
      div_type                st_in;
      logic [T_FRAC_BITS-1:0] q_in;
      logic [DSQ_W:0]         sh;
      logic                   ge;

      if (k == 0) begin : g_first
         assign src  = div_in;
         assign qsrc = '0;
      end else begin : g_rest
         assign src  = st_ff[k-1];
         assign qsrc = q_ff[k-1];
      end

      always_comb begin
         sh        = {src.rem, 1'b0};
         ge        = sh >= {1'b0, src.dsq};
         st_in     = src;
         st_in.rem = ge ? DSQ_W'(sh - {1'b0, src.dsq}) : sh[DSQ_W-1:0];
         q_in      = {qsrc[T_FRAC_BITS-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[k].vld <= 1'b0;
         end else if (adv) begin
            st_ff[k] <= st_in;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            q_ff[k] <= q_in;
         end
      end
   end

   always_comb begin
      out_vld = st_ff[T_FRAC_BITS-1].vld;
      geom    = st_ff[T_FRAC_BITS-1].g;
      if (!st_ff[T_FRAC_BITS-1].pos) begin
         tq = '0;
      end else if (st_ff[T_FRAC_BITS-1].sat) begin
         tq = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;
      end else begin
         tq = {1'b0, q_ff[T_FRAC_BITS-1]};
      end
   end

endmodule

// ===== rtl/ssit_back.sv =====
// back stages: closest point, distance squared and radius compare
// depends on ssit_pkg
module ssit_back #(
   parameter int T_FRAC_BITS = ssit_pkg::T_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_vld,
   input  logic [T_FRAC_BITS:0] tq,
   input  ssit_pkg::geom_type   geom,
   output logic                 out_vld,
   output logic                 out_hit
);
   import ssit_pkg::*;

   localparam int MW = T_FRAC_BITS + COORD_W + 1;
   localparam int PW = DIFF_W + 1;
   localparam int DW = DIFF_W + 2;
   localparam int SW = 2 * RAD_W;

   logic                 b1_vld_ff;
   logic [2:0][MW-1:0]   b1_m_ff, b1_m_in;
   geom_type             b1_g_ff;

   logic                 b2_vld_ff;
   logic [2:0][DW-1:0]   b2_d_ff, b2_d_in;
   logic [RAD_W-1:0]     b2_r_ff;

   logic                 b3_vld_ff;
   logic [2:0]           b3_far_ff, b3_far_in;
   logic [2:0][SW-1:0]   b3_sq_ff, b3_sq_in;
   logic [SW-1:0]        b3_rr_ff, b3_rr_in;

   logic                 b4_vld_ff;
   logic                 b4_hit_ff, b4_hit_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         b1_m_in[i] = MW'(tq) * MW'(geom.dmag[i]);
      end
   end

   always_comb begin
      logic [PW-1:0] q;
      logic [PW-1:0] p;
      for (int i = 0; i < 3; i++) begin
         q = PW'(b1_m_ff[i][MW-1:T_FRAC_BITS]);
         if (b1_g_ff.dneg[i]) begin
            p = -(q + PW'(|b1_m_ff[i][T_FRAC_BITS-1:0]));
         end else begin
            p = q;
         end
         b2_d_in[i] = DW'($signed(b1_g_ff.oc[i])) + DW'($signed(p));
      end
   end

   always_comb begin
      logic [DW-1:0] dm;
      for (int i = 0; i < 3; i++) begin
         dm           = b2_d_ff[i][DW-1] ? -b2_d_ff[i] : b2_d_ff[i];
         b3_far_in[i] = dm > DW'(b2_r_ff);
         b3_sq_in[i]  = SW'(dm[RAD_W-1:0]) * SW'(dm[RAD_W-1:0]);
      end
      b3_rr_in = SW'(b2_r_ff) * SW'(b2_r_ff);
   end

   always_comb begin
      logic [DSQ_W-1:0] sum;
      sum = DSQ_W'(b3_sq_ff[0]) + DSQ_W'(b3_sq_ff[1]) + DSQ_W'(b3_sq_ff[2]);
      b4_hit_in = (b3_far_ff == 3'b000) && (sum <= DSQ_W'(b3_rr_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff <= 1'b0;
         b2_vld_ff <= 1'b0;
         b3_vld_ff <= 1'b0;
         b4_vld_ff <= 1'b0;
      end else if (adv) begin
         b1_vld_ff <= in_vld;
         b2_vld_ff <= b1_vld_ff;
         b3_vld_ff <= b2_vld_ff;
         b4_vld_ff <= b3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_m_ff   <= b1_m_in;
         b1_g_ff   <= geom;
         b2_d_ff   <= b2_d_in;
         b2_r_ff   <= b1_g_ff.r;
         b3_far_ff <= b3_far_in;
         b3_sq_ff  <= b3_sq_in;
         b3_rr_ff  <= b3_rr_in;
         b4_hit_ff <= b4_hit_in;
      end
   end

   assign out_vld = b4_vld_ff;
   assign out_hit = b4_hit_ff;

endmodule

// ===== rtl/segment_sphere_intersect_test.sv =====
// channel   direction  contents
// req_*     in         segment origin, direction, sphere centre and radius
// rsp_*     out        hit flag, one per request
//
// one request enters every cycle unless rsp_stall holds the pipeline
// the divider pipeline, one quotient bit per stage, sets the depth
// reset is synchronous and clears all stage valid bits
// rsp_stall freezes the whole pipeline while a response waits
// top level of the segment/sphere test, depends on ssit_pkg, ssit_front,
// ssit_div, ssit_back and the assertion header
module segment_sphere_intersect_test #(
   parameter int T_FRAC_BITS = ssit_pkg::T_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ssit_pkg::COORD_W-1:0]      req_seg_origin_x,
   input  logic [ssit_pkg::COORD_W-1:0]      req_seg_origin_y,
   input  logic [ssit_pkg::COORD_W-1:0]      req_seg_origin_z,
   input  logic [ssit_pkg::COORD_W-1:0]      req_seg_dir_x,
   input  logic [ssit_pkg::COORD_W-1:0]      req_seg_dir_y,
   input  logic [ssit_pkg::COORD_W-1:0]      req_seg_dir_z,
   input  logic [ssit_pkg::COORD_W-1:0]      req_ball_center_x,
   input  logic [ssit_pkg::COORD_W-1:0]      req_ball_center_y,
   input  logic [ssit_pkg::COORD_W-1:0]      req_ball_center_z,
   input  logic [ssit_pkg::RAD_W-1:0]        req_ball_radius,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_hit
);
   import ssit_pkg::*;

   `include "segment_sphere_intersect_test_assert.svh"

   logic                  adv;
   div_type               front_out;
   logic                  div_vld;
   logic [T_FRAC_BITS:0]  div_tq;
   geom_type              div_geom;

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   ssit_front u_front (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (req_valid),
      .org     ({req_seg_origin_z, req_seg_origin_y, req_seg_origin_x}),
      .dir     ({req_seg_dir_z, req_seg_dir_y, req_seg_dir_x}),
      .cen     ({req_ball_center_z, req_ball_center_y, req_ball_center_x}),
      .rad     (req_ball_radius),
      .div_out (front_out)
   );

   ssit_div #(.T_FRAC_BITS(T_FRAC_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .div_in  (front_out),
      .out_vld (div_vld),
      .tq      (div_tq),
      .geom    (div_geom)
   );

   ssit_back #(.T_FRAC_BITS(T_FRAC_BITS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (div_vld),
      .tq      (div_tq),
      .geom    (div_geom),
      .out_vld (rsp_valid),
      .out_hit (rsp_hit)
   );

   `SSIT_ASSERT_IMPLIES(a_stall_cause, req_stall, rsp_valid && rsp_stall)
   `SSIT_ASSERT_IMPLIES(a_tq_range, div_vld, div_tq <= ((T_FRAC_BITS+1)'(1) << T_FRAC_BITS))
   `SSIT_ASSERT_NEXT(a_div_freeze, req_stall, $stable(div_tq) && $stable(div_vld))
   `SSIT_ASSERT_AFTER_RESET(a_reset_empty, !rsp_valid && !div_vld)

endmodule
